/* rtl/bla_pkg.sv */
// ----------------------------------------------------------------------------
// bla_pkg
// Shared types, constants and the control program of the battery level
// averager.
// ----------------------------------------------------------------------------
package bla_pkg;

   localparam int MV_W          = 13;
   localparam int TENTHS_W      = 7;
   localparam int LEVEL_W       = 8;
   localparam int AVG_SHIFT_DEF = 4;
   localparam int AVG_SHIFT_MAX = 8;

   // The shared divider must hold both the scaled level numerator and the
   // widest running sum.
   localparam int LEVEL_SCALE   = 20000;
   localparam int PCT_UNIT      = 100;
   localparam int LEVEL_MULT    = LEVEL_SCALE / PCT_UNIT;
   localparam int LEVEL_MAX     = 200;
   localparam int TENTHS_DIV    = 100;
   localparam int TENTHS_ROUND  = 50;
   localparam int DIV_W         = 21;
   localparam int IDX_W         = 5;

   // The 100 mV reading divides by a constant, done as a multiplication by
   // the rounded-up reciprocal. The error stays below one unit for every
   // rounded average up to full scale plus the rounding term.
   localparam int TENTHS_RECIP_SHIFT = 20;
   localparam int TENTHS_RECIP  = ((1 << TENTHS_RECIP_SHIFT) + TENTHS_DIV - 1) / TENTHS_DIV;
   localparam int TENTHS_PROD_W = 28;

   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 32;
   localparam int CSR_IDX_W     = 2;

   localparam logic [MV_W-1:0] LOW_RESET     = MV_W'(2000);
   localparam logic [MV_W-1:0] STARTUP_RESET = MV_W'(2200);
   localparam logic [MV_W-1:0] FULL_RESET    = MV_W'(3000);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOW     = 2'd0,
      REG_STARTUP = 2'd1,
      REG_FULL    = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_FULL_CHECK,
      OP_LOAD_AVG,
      OP_DIV_STEP,
      OP_STORE_AVG,
      OP_STORE_TENTHS,
      OP_LEVEL_CHECK,
      OP_LOAD_LEVEL,
      OP_STORE_LEVEL,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_FULL,
      COND_DIV_MORE,
      COND_LEVEL_TRIVIAL,
      COND_RSP_STALL
   } cond_type;

   localparam int PC_W = 4;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic full;
      logic div_more;
      logic level_trivial;
      logic rsp_stall;
   } status_type;

   localparam logic [PC_W-1:0] PC_ACCEPT  = PC_W'(0);
   localparam logic [PC_W-1:0] PC_AVG_DIV = PC_W'(3);
   localparam logic [PC_W-1:0] PC_TENTHS  = PC_W'(5);
   localparam logic [PC_W-1:0] PC_LVL_DIV = PC_W'(8);
   localparam logic [PC_W-1:0] PC_EMIT    = PC_W'(10);

   // Control program. A step jumps to its target when its condition holds
   // and otherwise falls through to the next step.
   function automatic ucode_type ucode_word(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_ACCEPT};
      unique case (pc)
         4'd0:    w = '{op: OP_ACCEPT,       cond: COND_NO_REQ,        target: PC_ACCEPT};
         4'd1:    w = '{op: OP_FULL_CHECK,   cond: COND_FULL,          target: PC_TENTHS};
         4'd2:    w = '{op: OP_LOAD_AVG,     cond: COND_NEXT,          target: PC_ACCEPT};
         4'd3:    w = '{op: OP_DIV_STEP,     cond: COND_DIV_MORE,      target: PC_AVG_DIV};
         4'd4:    w = '{op: OP_STORE_AVG,    cond: COND_NEXT,          target: PC_ACCEPT};
         4'd5:    w = '{op: OP_STORE_TENTHS, cond: COND_NEXT,          target: PC_ACCEPT};
         4'd6:    w = '{op: OP_LEVEL_CHECK,  cond: COND_LEVEL_TRIVIAL, target: PC_EMIT};
         4'd7:    w = '{op: OP_LOAD_LEVEL,   cond: COND_NEXT,          target: PC_ACCEPT};
         4'd8:    w = '{op: OP_DIV_STEP,     cond: COND_DIV_MORE,      target: PC_LVL_DIV};
         4'd9:    w = '{op: OP_STORE_LEVEL,  cond: COND_NEXT,          target: PC_ACCEPT};
         4'd10:   w = '{op: OP_EMIT,         cond: COND_RSP_STALL,     target: PC_EMIT};
         default: w = '{op: OP_NOP,          cond: COND_ALWAYS,        target: PC_ACCEPT};
      endcase
      return w;
   endfunction

endpackage

/* rtl/battery_level_averager.sv */
// ----------------------------------------------------------------------------
// battery_level_averager
// Leaky moving average of battery voltage with low flag, 100 mV reading and
// half-percent charge level.
// ----------------------------------------------------------------------------
// Each word on the request stream carries one battery sample in millivolts
// and a startup flag; each produces exactly one response word. The low flag
// compares the raw sample with the startup or the low threshold. The sample
// joins a running sum: until 2^AVG_SHIFT samples are held the average is the
// plain mean, after that it is the sum shifted right by AVG_SHIFT, which is
// then leaked back out of the sum. The average is also given in 100 mV units,
// rounded, and as a charge level from 0 to 200 half-percent between the low
// and full thresholds. A small control program steps a plain datapath. The
// mean and the level divisions share one radix-2 divider that yields one
// quotient bit per cycle; the 100 mV reading is a combinational
// multiplication by the reciprocal of 100. The warm-up mean division is
// skipped once the window is full, and the level division is skipped when
// the average is at or below the low threshold or the full threshold is
// not above the low one. A word takes longer while the previous response
// word still waits on the output. A new request is taken while the
// previous response still waits on the output. Threshold writes are
// accepted in any cycle and should be made while the block is idle.
// ----------------------------------------------------------------------------
module battery_level_averager #(
   parameter int AVG_SHIFT = bla_pkg::AVG_SHIFT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bla_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [12:0] sample_mv
   input  logic                              req_tuser,   // [0] startup
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bla_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [12:0] mean_mv,
                                                          // [19:13] voltage_tenths,
                                                          // [27:20] level_half_percent
   output logic                              rsp_tuser,   // [0] low_battery
   // Threshold register writes.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bla_pkg::MV_W-1:0]          csr_data
);
   import bla_pkg::*;

   logic [MV_W-1:0] low_thr_ff, low_thr_in;
   logic [MV_W-1:0] start_thr_ff, start_thr_in;
   logic [MV_W-1:0] full_thr_ff, full_thr_in;
   op_type          op;
   status_type      status;

   // Writes to an index outside the register list are dropped.
   always_comb begin
      low_thr_in   = low_thr_ff;
      start_thr_in = start_thr_ff;
      full_thr_in  = full_thr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_LOW:     low_thr_in   = csr_data;
            REG_STARTUP: start_thr_in = csr_data;
            REG_FULL:    full_thr_in  = csr_data;
            default:     low_thr_in   = low_thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff   <= LOW_RESET;
         start_thr_ff <= STARTUP_RESET;
         full_thr_ff  <= FULL_RESET;
      end else begin
         low_thr_ff   <= low_thr_in;
         start_thr_ff <= start_thr_in;
         full_thr_ff  <= full_thr_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = op == OP_ACCEPT;

   bla_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   bla_datapath #(
      .AVG_SHIFT (AVG_SHIFT)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .op                   (op),
      .req_tvalid           (req_tvalid),
      .sample_mv            (req_tdata[MV_W-1:0]),
      .startup              (req_tuser),
      .low_threshold_mv     (low_thr_ff),
      .startup_threshold_mv (start_thr_ff),
      .full_threshold_mv    (full_thr_ff),
      .status               (status),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_tdata            (rsp_tdata),
      .rsp_tuser            (rsp_tuser)
   );

endmodule

/* rtl/bla_divider.sv */
// ----------------------------------------------------------------------------
// bla_divider
// Radix-2 restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module bla_divider (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        step,
   input  logic [bla_pkg::DIV_W-1:0]   dividend,
   input  logic [bla_pkg::MV_W-1:0]    divisor,
   input  logic [bla_pkg::IDX_W-1:0]   top_bit,
   output logic [bla_pkg::DIV_W-1:0]   quotient,
   output logic                        more
);
   import bla_pkg::*;

   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [MV_W-1:0]  dvs_ff, dvs_in;
   logic [MV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [MV_W:0]    trial;
   logic             fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[idx_ff]};
      fits  = trial >= {1'b0, dvs_ff};
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      idx_in = idx_ff;
      if (load) begin
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         quo_in = '0;
         idx_in = top_bit;
      end else if (step) begin
         // The remainder stays below the divisor, so it fits the divisor width.
         rem_in = fits ? MV_W'(trial - {1'b0, dvs_ff}) : MV_W'(trial);
         quo_in = {quo_ff[DIV_W-2:0], fits};
         if (idx_ff != '0) begin
            idx_in = idx_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      idx_ff <= idx_in;
   end

   assign quotient = quo_ff;
   assign more     = idx_ff != '0;

endmodule

/* rtl/bla_datapath.sv */
// ----------------------------------------------------------------------------
// bla_datapath
// Running sum and count, result registers and the output word register,
// driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module bla_datapath #(
   parameter int AVG_SHIFT = bla_pkg::AVG_SHIFT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bla_pkg::op_type                  op,
   input  logic                             req_tvalid,
   input  logic [bla_pkg::MV_W-1:0]         sample_mv,
   input  logic                             startup,
   input  logic [bla_pkg::MV_W-1:0]         low_threshold_mv,
   input  logic [bla_pkg::MV_W-1:0]         startup_threshold_mv,
   input  logic [bla_pkg::MV_W-1:0]         full_threshold_mv,
   output bla_pkg::status_type              status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bla_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser
);
   import bla_pkg::*;

   localparam int SUM_W = MV_W + AVG_SHIFT;
   localparam int CNT_W = AVG_SHIFT + 1;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                low_ff, low_in;
   logic [MV_W-1:0]     avg_ff, avg_in;
   logic [TENTHS_W-1:0] tenths_ff, tenths_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_low_ff, rsp_low_in;

   logic                full;
   logic [SUM_W-1:0]    leak;
   logic                div_load;
   logic [DIV_W-1:0]    div_dividend;
   logic [MV_W-1:0]     div_divisor;
   logic [IDX_W-1:0]    div_top;
   logic [DIV_W-1:0]    quotient;
   logic                div_more;
   logic [MV_W-1:0]     level_span;
   logic                emit_ok;
   logic [TENTHS_PROD_W-1:0] tenths_prod;

   assign full    = count_ff[AVG_SHIFT];
   assign leak    = sum_ff >> AVG_SHIFT;
   assign emit_ok = !rsp_valid_ff || rsp_tready;

   // Rounded average over 100 by reciprocal multiplication.
   assign tenths_prod = (TENTHS_PROD_W'(avg_ff) + TENTHS_PROD_W'(TENTHS_ROUND)) *
                        TENTHS_PROD_W'(TENTHS_RECIP);

   // Divider operand selection for the two divisions of one word.
   always_comb begin
      level_span   = avg_ff - low_threshold_mv;
      div_load     = 1'b0;
      div_dividend = DIV_W'(sum_ff);
      div_divisor  = MV_W'(count_ff);
      div_top      = IDX_W'(SUM_W - 1);
      unique case (op)
         OP_LOAD_AVG: begin
            div_load = 1'b1;
         end
         OP_LOAD_LEVEL: begin
            div_load     = 1'b1;
            div_dividend = DIV_W'(level_span) * DIV_W'(LEVEL_MULT);
            div_divisor  = full_threshold_mv - low_threshold_mv;
            div_top      = IDX_W'(DIV_W - 1);
         end
         default: begin
            div_load = 1'b0;
         end
      endcase
   end

   bla_divider u_divider (
      .clock    (clock),
      .load     (div_load),
      .step     (op == OP_DIV_STEP),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .top_bit  (div_top),
      .quotient (quotient),
      .more     (div_more)
   );

   always_comb begin
      sum_in       = sum_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      avg_in       = avg_ff;
      tenths_in    = tenths_ff;
      level_in     = level_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (op)
         OP_ACCEPT: begin
            if (req_tvalid) begin
               sum_in   = sum_ff + SUM_W'(sample_mv);
               count_in = count_ff + CNT_W'(1);
               low_in   = sample_mv < (startup ? startup_threshold_mv : low_threshold_mv);
            end
         end
         OP_FULL_CHECK: begin
            // A full window averages by shift and leaks that average back out.
            if (full) begin
               avg_in   = MV_W'(leak);
               sum_in   = sum_ff - leak;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_STORE_AVG:    avg_in    = quotient[MV_W-1:0];
         OP_STORE_TENTHS: tenths_in = tenths_prod[TENTHS_RECIP_SHIFT +: TENTHS_W];
         OP_LEVEL_CHECK: begin
            level_in = (avg_ff <= low_threshold_mv) ? '0 : LEVEL_W'(LEVEL_MAX);
         end
         OP_STORE_LEVEL: begin
            level_in = (quotient > DIV_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                      : quotient[LEVEL_W-1:0];
         end
         OP_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_low_in   = low_ff;
               rsp_data_in  = RSP_TDATA_W'({level_ff, tenths_ff, avg_ff});
            end
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff      <= low_in;
      avg_ff      <= avg_in;
      tenths_ff   <= tenths_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
      rsp_low_ff  <= rsp_low_in;
   end

   always_comb begin
      status.no_req        = !req_tvalid;
      status.full          = full;
      status.div_more      = div_more;
      status.level_trivial = (avg_ff <= low_threshold_mv) ||
                             (full_threshold_mv <= low_threshold_mv);
      status.rsp_stall     = !emit_ok;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_low_ff;

endmodule

/* rtl/bla_sequencer.sv */
// ----------------------------------------------------------------------------
// bla_sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
module bla_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  bla_pkg::status_type status,
   output bla_pkg::op_type     op
);
   import bla_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       word;
   logic            take;

   always_comb begin
      word = ucode_word(pc_ff);
      unique case (word.cond)
         COND_NEXT:          take = 1'b0;
         COND_ALWAYS:        take = 1'b1;
         COND_NO_REQ:        take = status.no_req;
         COND_FULL:          take = status.full;
         COND_DIV_MORE:      take = status.div_more;
         COND_LEVEL_TRIVIAL: take = status.level_trivial;
         COND_RSP_STALL:     take = status.rsp_stall;
         default:            take = 1'b0;
      endcase
      pc_in = take ? word.target : pc_ff + PC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = word.op;

endmodule
